FILE: hdl/pvt_pkg.sv
// ----------------------------------------------------------------------------
// pvt_pkg
// Shared types, codes and helpers of the page validity tracker: action
// codes, controller states, the command and status groups between the
// controller and the datapath, and the byte population count.
// ----------------------------------------------------------------------------
package pvt_pkg;

  localparam int ACTION_W = 2;
  localparam int FLASH_W  = 4;
  localparam int PLANE_W  = 3;
  localparam int BLOCK_W  = 12;
  localparam int PAGE_W   = 6;
  localparam int TYPE_W   = 3;
  localparam int COUNT_W  = 7;
  localparam int GROUP_W  = 8;
  localparam int GCNT_W   = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MARK_VALID   = 2'd0,
    ACT_MARK_INVALID = 2'd1,
    ACT_SET_TYPE     = 2'd2,
    ACT_COUNT        = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic write_back;
    logic latch_part;
    logic load_out;
    logic load_sum;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic is_count;
    logic clear_last;
  } sts_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  function automatic logic [GCNT_W-1:0] popcount8(input logic [GROUP_W-1:0] v);
    logic [GCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      n = n + GCNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: hdl/pvt_ctrl.sv
// ----------------------------------------------------------------------------
// pvt_ctrl
// Controller of the page validity tracker: sequences the clearing pass,
// request acceptance, read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
module pvt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  pvt_pkg::sts_t sts,
  output pvt_pkg::cmd_t cmd
);

  pvt_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != pvt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pvt_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      pvt_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = pvt_pkg::ST_IDLE;
        end
      end
      pvt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = pvt_pkg::ST_MODIFY;
        end
      end
      pvt_pkg::ST_MODIFY: begin
        if (sts.is_count && !sts.bad) begin
          cmd.latch_part = 1'b1;
          state_next     = pvt_pkg::ST_SUM;
        end else if (out_free) begin
          cmd.write_back = !sts.bad;
          cmd.load_out   = 1'b1;
          state_next     = pvt_pkg::ST_IDLE;
        end
      end
      pvt_pkg::ST_SUM: begin
        if (out_free) begin
          cmd.load_sum = 1'b1;
          state_next   = pvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pvt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out || cmd.load_sum) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: hdl/pvt_dp.sv
// ----------------------------------------------------------------------------
// pvt_dp
// Datapath of the page validity tracker: block row memory, request
// registers, row update logic, bit counting and the result register.
// ----------------------------------------------------------------------------
module pvt_dp #(
  parameter int FLASH_COUNT      = 4,
  parameter int PLANES_PER_FLASH = 2,
  parameter int BLOCKS_PER_PLANE = 256,
  parameter int PAGES_PER_BLOCK  = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pvt_pkg::TYPE_W-1:0]   cfg_wdata,
  input  logic [pvt_pkg::ACTION_W-1:0] action,
  input  logic [pvt_pkg::FLASH_W-1:0]  flash_number,
  input  logic [pvt_pkg::PLANE_W-1:0]  plane_number,
  input  logic [pvt_pkg::BLOCK_W-1:0]  block_number,
  input  logic [pvt_pkg::PAGE_W-1:0]   page_number,
  input  logic [pvt_pkg::TYPE_W-1:0]   new_block_type,
  input  pvt_pkg::cmd_t                cmd,
  output pvt_pkg::sts_t                sts,
  output logic                         status,
  output logic [pvt_pkg::COUNT_W-1:0]  valid_count,
  output logic [pvt_pkg::TYPE_W-1:0]   block_type_now
);

  localparam int ROW_COUNT = FLASH_COUNT * PLANES_PER_FLASH * BLOCKS_PER_PLANE;
  localparam int ROW_AW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int PAGE_AW   = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
  localparam int ROW_W     = PAGES_PER_BLOCK + pvt_pkg::COUNT_W + pvt_pkg::TYPE_W;
  localparam int CNT_LO    = PAGES_PER_BLOCK;
  localparam int TYPE_LO   = PAGES_PER_BLOCK + pvt_pkg::COUNT_W;
  localparam int GROUPS    = (PAGES_PER_BLOCK + pvt_pkg::GROUP_W - 1) / pvt_pkg::GROUP_W;

  logic [ROW_W-1:0] mem [ROW_COUNT];
  logic [ROW_W-1:0] rdata;

  logic [pvt_pkg::TYPE_W-1:0] empty_type_code;
  logic [ROW_AW-1:0]          clr_cnt;

  pvt_pkg::action_t           action_in;
  logic [ROW_AW-1:0]          row_in;
  logic                       bad_in;

  pvt_pkg::action_t           req_action;
  logic [ROW_AW-1:0]          req_row;
  logic [PAGE_AW-1:0]         req_page;
  logic [pvt_pkg::TYPE_W-1:0] req_type;
  logic                       req_bad;

  logic [PAGES_PER_BLOCK-1:0]  rd_bits;
  logic [pvt_pkg::COUNT_W-1:0] rd_cnt;
  logic [pvt_pkg::TYPE_W-1:0]  rd_type;
  logic [PAGES_PER_BLOCK-1:0]  page_sel;
  logic [PAGES_PER_BLOCK-1:0]  new_bits;
  logic [pvt_pkg::COUNT_W-1:0] new_cnt;
  logic [pvt_pkg::TYPE_W-1:0]  new_type;
  logic [ROW_W-1:0]            new_row;

  logic [GROUPS*pvt_pkg::GROUP_W-1:0] padded;
  logic [pvt_pkg::GCNT_W-1:0]         part [GROUPS];
  logic [pvt_pkg::COUNT_W-1:0]        part_sum;

  // Request decode on the input ports
  assign action_in = pvt_pkg::action_t'(action);
  assign row_in = ROW_AW'((32'(flash_number) * 32'(PLANES_PER_FLASH) + 32'(plane_number))
                          * 32'(BLOCKS_PER_PLANE) + 32'(block_number));
  assign bad_in = (32'(flash_number) >= 32'(FLASH_COUNT))
               || (32'(plane_number) >= 32'(PLANES_PER_FLASH))
               || (32'(block_number) >= 32'(BLOCKS_PER_PLANE))
               || (((action_in == pvt_pkg::ACT_MARK_VALID)
                    || (action_in == pvt_pkg::ACT_MARK_INVALID))
                   && (32'(page_number) >= 32'(PAGES_PER_BLOCK)));

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_type_code <= '0;
      clr_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        empty_type_code <= cfg_wdata;
      end
      if (cmd.clear_wr && !sts.clear_last) begin
        clr_cnt <= clr_cnt + ROW_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_action <= action_in;
      req_row    <= row_in;
      req_page   <= page_number[PAGE_AW-1:0];
      req_type   <= new_block_type;
      req_bad    <= bad_in;
    end
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.write_back) begin
      mem[req_row] <= new_row;
    end
    if (cmd.accept) begin
      rdata <= mem[row_in];
    end
  end

  assign rd_bits  = rdata[PAGES_PER_BLOCK-1:0];
  assign rd_cnt   = rdata[CNT_LO +: pvt_pkg::COUNT_W];
  assign rd_type  = rdata[TYPE_LO +: pvt_pkg::TYPE_W];
  assign page_sel = PAGES_PER_BLOCK'(1) << req_page;

  always_comb begin
    new_bits = rd_bits;
    new_cnt  = rd_cnt;
    new_type = rd_type;
    case (req_action)
      pvt_pkg::ACT_MARK_VALID: begin
        new_bits = rd_bits | page_sel;
        if (32'(rd_cnt) < 32'(PAGES_PER_BLOCK)) begin
          new_cnt = rd_cnt + pvt_pkg::COUNT_W'(1);
        end
      end
      pvt_pkg::ACT_MARK_INVALID: begin
        new_bits = rd_bits & ~page_sel;
        if (rd_cnt != '0) begin
          new_cnt = rd_cnt - pvt_pkg::COUNT_W'(1);
        end
      end
      pvt_pkg::ACT_SET_TYPE: begin
        new_type = req_type;
        if (req_type == empty_type_code) begin
          new_bits = '0;
          new_cnt  = '0;
        end
      end
      default: begin
        new_bits = rd_bits;
      end
    endcase
  end

  assign new_row = {new_type, new_cnt, new_bits};

  // Bit count: per-byte counts first, then their sum
  assign padded = (GROUPS*pvt_pkg::GROUP_W)'(rd_bits);

  always_ff @(posedge clk) begin
    if (cmd.latch_part) begin
      for (int g = 0; g < GROUPS; g++) begin
        part[g] <= pvt_pkg::popcount8(padded[g*pvt_pkg::GROUP_W +: pvt_pkg::GROUP_W]);
      end
    end
  end

  always_comb begin
    part_sum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      part_sum = part_sum + pvt_pkg::COUNT_W'(part[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (req_bad) begin
        status         <= pvt_pkg::STATUS_BAD;
        valid_count    <= '0;
        block_type_now <= '0;
      end else begin
        status         <= pvt_pkg::STATUS_OK;
        valid_count    <= new_cnt;
        block_type_now <= new_type;
      end
    end else if (cmd.load_sum) begin
      status         <= pvt_pkg::STATUS_OK;
      valid_count    <= part_sum;
      block_type_now <= rd_type;
    end
  end

  assign sts.bad        = req_bad;
  assign sts.is_count   = (req_action == pvt_pkg::ACT_COUNT);
  assign sts.clear_last = (clr_cnt == ROW_AW'(ROW_COUNT - 1));

endmodule

FILE: hdl/page_validity_tracker_top.sv
// ----------------------------------------------------------------------------
// page_validity_tracker_top
// Block state table: page-valid bitmap, valid-page count and type per block.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with their fields on separate ports;
//   one result per request leaves on out_valid/out_stall. A request is taken
//   at an edge with in_valid high and in_stall low.
//   Each request reads its block row from a row memory with one write
//   port and one registered read port; an in-range mark or type request
//   writes the updated row back. The result is registered once the result
//   register is free; the count action sums per-byte counts in a
//   second step. No request is taken until the previous result is loaded.
//   After reset the block clears every row, FLASH_COUNT * PLANES_PER_FLASH *
//   BLOCKS_PER_PLANE rows (2048 by default), holding in_stall high;
//   cfg_we writes the empty type code at any time.
//   While out_stall holds a result, one further request is taken and then
//   held before write-back until the result register frees.
// ----------------------------------------------------------------------------
module page_validity_tracker_top #(
  parameter int FLASH_COUNT      = 4,
  parameter int PLANES_PER_FLASH = 2,
  parameter int BLOCKS_PER_PLANE = 256,
  parameter int PAGES_PER_BLOCK  = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pvt_pkg::TYPE_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pvt_pkg::ACTION_W-1:0] action,
  input  logic [pvt_pkg::FLASH_W-1:0]  flash_number,
  input  logic [pvt_pkg::PLANE_W-1:0]  plane_number,
  input  logic [pvt_pkg::BLOCK_W-1:0]  block_number,
  input  logic [pvt_pkg::PAGE_W-1:0]   page_number,
  input  logic [pvt_pkg::TYPE_W-1:0]   new_block_type,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         status,
  output logic [pvt_pkg::COUNT_W-1:0]  valid_count,
  output logic [pvt_pkg::TYPE_W-1:0]   block_type_now
);

  pvt_pkg::cmd_t cmd;
  pvt_pkg::sts_t sts;

  pvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pvt_dp #(
    .FLASH_COUNT      (FLASH_COUNT),
    .PLANES_PER_FLASH (PLANES_PER_FLASH),
    .BLOCKS_PER_PLANE (BLOCKS_PER_PLANE),
    .PAGES_PER_BLOCK  (PAGES_PER_BLOCK)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .action         (action),
    .flash_number   (flash_number),
    .plane_number   (plane_number),
    .block_number   (block_number),
    .page_number    (page_number),
    .new_block_type (new_block_type),
    .cmd            (cmd),
    .sts            (sts),
    .status         (status),
    .valid_count    (valid_count),
    .block_type_now (block_type_now)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in flight");

  a_bad_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pvt_pkg::STATUS_BAD) |-> (valid_count == '0)
      && (block_type_now == '0))
    else $error("out-of-range result carries non-zero fields");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(valid_count) <= 32'(PAGES_PER_BLOCK)))
    else $error("valid count exceeds page count");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no request in flight");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page validity tracker. Requests go in through
// one shared send task; a separate process checks each result, field by
// field, against the oldest entry of a queue. That queue is filled by a
// predictor that keeps its own copy of the bitmap, count and type tables
// and of the empty type code. Named tests cover page marks, type setting,
// out-of-range addresses, count saturation and output back-pressure, then
// run several random phases with different empty codes and idle patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FLASHES        = 4;
  localparam int PLANES         = 2;
  localparam int BLOCKS         = 256;
  localparam int PAGES          = 64;
  localparam int ROWS           = FLASHES * PLANES * BLOCKS;
  localparam int HOT_ROWS       = 8;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    pvt_pkg::action_t             act;
    logic [pvt_pkg::FLASH_W-1:0]  flash;
    logic [pvt_pkg::PLANE_W-1:0]  plane;
    logic [pvt_pkg::BLOCK_W-1:0]  block;
    logic [pvt_pkg::PAGE_W-1:0]   page;
    logic [pvt_pkg::TYPE_W-1:0]   new_type;
  } request_t;

  typedef struct {
    logic                        status;
    logic [pvt_pkg::COUNT_W-1:0] count;
    logic [pvt_pkg::TYPE_W-1:0]  kind;
  } outcome_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [pvt_pkg::TYPE_W-1:0]   cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic [pvt_pkg::ACTION_W-1:0] action;
  logic [pvt_pkg::FLASH_W-1:0]  flash_number;
  logic [pvt_pkg::PLANE_W-1:0]  plane_number;
  logic [pvt_pkg::BLOCK_W-1:0]  block_number;
  logic [pvt_pkg::PAGE_W-1:0]   page_number;
  logic [pvt_pkg::TYPE_W-1:0]   new_block_type;
  logic                         out_valid;
  logic                         out_stall;
  logic                         status;
  logic [pvt_pkg::COUNT_W-1:0]  valid_count;
  logic [pvt_pkg::TYPE_W-1:0]   block_type_now;

  bit [63:0]                 row_bitmap [ROWS];
  bit [pvt_pkg::COUNT_W-1:0] row_tally  [ROWS];
  bit [pvt_pkg::TYPE_W-1:0]  row_kind   [ROWS];
  bit [pvt_pkg::TYPE_W-1:0]  empty_code;

  logic [pvt_pkg::FLASH_W-1:0] hot_flash [HOT_ROWS];
  logic [pvt_pkg::PLANE_W-1:0] hot_plane [HOT_ROWS];
  logic [pvt_pkg::BLOCK_W-1:0] hot_block [HOT_ROWS];

  outcome_t pending_outcomes [$];

  bit tx_gaps_on;
  bit rx_gaps_on;
  int hold_cycles;
  int mismatches;
  int requests_sent;
  int requests_bad;
  int results_checked;
  int code_writes;

  page_validity_tracker_top #(
    .FLASH_COUNT      (FLASHES),
    .PLANES_PER_FLASH (PLANES),
    .BLOCKS_PER_PLANE (BLOCKS),
    .PAGES_PER_BLOCK  (PAGES)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .flash_number   (flash_number),
    .plane_number   (plane_number),
    .block_number   (block_number),
    .page_number    (page_number),
    .new_block_type (new_block_type),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .valid_count    (valid_count),
    .block_type_now (block_type_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic outcome_t apply_request(input request_t r);
    outcome_t o;
    int       row;
    o.status = pvt_pkg::STATUS_BAD;
    o.count  = '0;
    o.kind   = '0;
    if (r.flash >= FLASHES || r.plane >= PLANES || r.block >= BLOCKS ||
        ((r.act == pvt_pkg::ACT_MARK_VALID || r.act == pvt_pkg::ACT_MARK_INVALID)
         && r.page >= PAGES)) begin
      return o;
    end
    row = (int'(r.flash) * PLANES + int'(r.plane)) * BLOCKS + int'(r.block);
    o.status = pvt_pkg::STATUS_OK;
    case (r.act)
      pvt_pkg::ACT_MARK_VALID: begin
        row_bitmap[row][r.page] = 1'b1;
        if (row_tally[row] < PAGES) row_tally[row] = row_tally[row] + 1'b1;
        o.count = row_tally[row];
      end
      pvt_pkg::ACT_MARK_INVALID: begin
        row_bitmap[row][r.page] = 1'b0;
        if (row_tally[row] > 0) row_tally[row] = row_tally[row] - 1'b1;
        o.count = row_tally[row];
      end
      pvt_pkg::ACT_SET_TYPE: begin
        row_kind[row] = r.new_type;
        if (r.new_type == empty_code) begin
          row_bitmap[row] = '0;
          row_tally[row]  = '0;
        end
        o.count = row_tally[row];
      end
      default: begin
        o.count = pvt_pkg::COUNT_W'($countones(row_bitmap[row]));
      end
    endcase
    o.kind = row_kind[row];
    return o;
  endfunction

  function automatic request_t make_request(input pvt_pkg::action_t a, input int f,
                                            input int p, input int b, input int pg,
                                            input int t);
    request_t r;
    r.act      = a;
    r.flash    = pvt_pkg::FLASH_W'(f);
    r.plane    = pvt_pkg::PLANE_W'(p);
    r.block    = pvt_pkg::BLOCK_W'(b);
    r.page     = pvt_pkg::PAGE_W'(pg);
    r.new_type = pvt_pkg::TYPE_W'(t);
    return r;
  endfunction

  function automatic void pick_hot_rows();
    hot_flash[0] = '0;
    hot_plane[0] = '0;
    hot_block[0] = '0;
    hot_flash[1] = pvt_pkg::FLASH_W'(FLASHES - 1);
    hot_plane[1] = pvt_pkg::PLANE_W'(PLANES - 1);
    hot_block[1] = pvt_pkg::BLOCK_W'(BLOCKS - 1);
    for (int i = 2; i < HOT_ROWS; i++) begin
      hot_flash[i] = pvt_pkg::FLASH_W'($urandom_range(0, FLASHES - 1));
      hot_plane[i] = pvt_pkg::PLANE_W'($urandom_range(0, PLANES - 1));
      hot_block[i] = pvt_pkg::BLOCK_W'($urandom_range(0, BLOCKS - 1));
    end
  endfunction

  function automatic request_t draw_request();
    request_t r;
    int       pick;
    int       h;
    pick       = $urandom_range(0, 99);
    r.act      = pvt_pkg::action_t'($urandom_range(0, 3));
    r.flash    = pvt_pkg::FLASH_W'($urandom_range(0, 15));
    r.plane    = pvt_pkg::PLANE_W'($urandom_range(0, 7));
    r.block    = pvt_pkg::BLOCK_W'($urandom_range(0, 4095));
    r.page     = pvt_pkg::PAGE_W'($urandom_range(0, 63));
    r.new_type = pvt_pkg::TYPE_W'($urandom_range(0, 7));
    if (pick < 85) begin
      h       = $urandom_range(0, HOT_ROWS - 1);
      r.flash = hot_flash[h];
      r.plane = hot_plane[h];
      r.block = hot_block[h];
      pick    = $urandom_range(0, 99);
      if (pick < 40)      r.act = pvt_pkg::ACT_MARK_VALID;
      else if (pick < 65) r.act = pvt_pkg::ACT_MARK_INVALID;
      else if (pick < 80) r.act = pvt_pkg::ACT_SET_TYPE;
      else                r.act = pvt_pkg::ACT_COUNT;
      if (r.act == pvt_pkg::ACT_SET_TYPE && $urandom_range(0, 2) == 0)
        r.new_type = empty_code;
    end else if (pick < 92) begin
      r.flash = pvt_pkg::FLASH_W'($urandom_range(0, FLASHES - 1));
      r.plane = pvt_pkg::PLANE_W'($urandom_range(0, PLANES - 1));
      r.block = pvt_pkg::BLOCK_W'($urandom_range(0, BLOCKS - 1));
    end
    return r;
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    action         <= r.act;
    flash_number   <= r.flash;
    plane_number   <= r.plane;
    block_number   <= r.block;
    page_number    <= r.page;
    new_block_type <= r.new_type;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(apply_request(r));
    requests_sent++;
    if (pending_outcomes[$].status == pvt_pkg::STATUS_BAD) requests_bad++;
  endtask

  task automatic finish_burst();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_empty_code(input logic [pvt_pkg::TYPE_W-1:0] code);
    finish_burst();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(negedge clk);
    cfg_we     <= 1'b0;
    empty_code = code;
    code_writes++;
  endtask

  task automatic test_reset_state();
    write_empty_code(3'd0);
    send_request(make_request(pvt_pkg::ACT_COUNT, 0, 0, 0, 0, 0));
    send_request(make_request(pvt_pkg::ACT_COUNT, FLASHES - 1, PLANES - 1, BLOCKS - 1,
                              63, 7));
  endtask

  task automatic test_page_marks();
    send_request(make_request(pvt_pkg::ACT_MARK_VALID, 0, 0, 0, 0, 0));
    send_request(make_request(pvt_pkg::ACT_MARK_VALID, 0, 0, 0, 63, 0));
    send_request(make_request(pvt_pkg::ACT_MARK_VALID, 0, 0, 0, 63, 0));
    send_request(make_request(pvt_pkg::ACT_COUNT, 0, 0, 0, 0, 0));
    send_request(make_request(pvt_pkg::ACT_MARK_INVALID, 0, 0, 0, 5, 0));
    send_request(make_request(pvt_pkg::ACT_MARK_INVALID, FLASHES - 1, PLANES - 1,
                              BLOCKS - 1, 63, 7));
    send_request(make_request(pvt_pkg::ACT_COUNT, FLASHES - 1, PLANES - 1, BLOCKS - 1,
                              63, 7));
  endtask

  task automatic test_block_type();
    send_request(make_request(pvt_pkg::ACT_SET_TYPE, 0, 0, 0, 63, 3));
    send_request(make_request(pvt_pkg::ACT_COUNT, 0, 0, 0, 17, 0));
    send_request(make_request(pvt_pkg::ACT_SET_TYPE, 0, 0, 0, 0, 0));
    send_request(make_request(pvt_pkg::ACT_COUNT, 0, 0, 0, 0, 0));
    write_empty_code(3'd7);
    send_request(make_request(pvt_pkg::ACT_MARK_VALID, 0, 0, 0, 10, 0));
    send_request(make_request(pvt_pkg::ACT_SET_TYPE, 0, 0, 0, 10, 0));
    send_request(make_request(pvt_pkg::ACT_SET_TYPE, 0, 0, 0, 10, 7));
    send_request(make_request(pvt_pkg::ACT_COUNT, 0, 0, 0, 10, 0));
  endtask

  task automatic test_out_of_range();
    send_request(make_request(pvt_pkg::ACT_MARK_VALID, 15, 7, 4095, 63, 7));
    send_request(make_request(pvt_pkg::ACT_MARK_INVALID, 15, 7, 4095, 63, 7));
    send_request(make_request(pvt_pkg::ACT_SET_TYPE, 15, 7, 4095, 63, 7));
    send_request(make_request(pvt_pkg::ACT_COUNT, 15, 7, 4095, 63, 7));
    send_request(make_request(pvt_pkg::ACT_MARK_VALID, FLASHES, 0, 0, 0, 0));
    send_request(make_request(pvt_pkg::ACT_SET_TYPE, 0, PLANES, 0, 0, 1));
    send_request(make_request(pvt_pkg::ACT_COUNT, 0, 0, BLOCKS, 0, 0));
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < PAGES + 6; i++) begin
      send_request(make_request(pvt_pkg::ACT_MARK_VALID, 2, 1, 77,
                                $urandom_range(0, 63), 0));
    end
    send_request(make_request(pvt_pkg::ACT_COUNT, 2, 1, 77, 0, 0));
    for (int i = 0; i < PAGES + 6; i++) begin
      send_request(make_request(pvt_pkg::ACT_MARK_INVALID, 2, 1, 77,
                                $urandom_range(0, 63), 0));
    end
    send_request(make_request(pvt_pkg::ACT_COUNT, 2, 1, 77, 0, 0));
  endtask

  task automatic test_back_pressure();
    finish_burst();
    tx_gaps_on  = 1'b0;
    hold_cycles = LONG_HOLD;
    for (int i = 0; i < 8; i++) begin
      send_request(draw_request());
    end
    finish_burst();
  endtask

  task automatic test_random_traffic(input int count,
                                     input logic [pvt_pkg::TYPE_W-1:0] code,
                                     input bit tx_gaps, input bit rx_gaps);
    write_empty_code(code);
    tx_gaps_on = tx_gaps;
    rx_gaps_on = rx_gaps;
    pick_hot_rows();
    for (int i = 0; i < count; i++) begin
      send_request(draw_request());
    end
  endtask

  // Receiver: drop out_stall for one result after a random pause or a long hold
  initial begin : result_drain
    int pause;
    out_stall <= 1'b0;
    forever begin
      pause = rx_gaps_on ? $urandom_range(0, 19) : 0;
      if (hold_cycles > 0) begin
        pause       = hold_cycles;
        hold_cycles = 0;
      end
      if (pause > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (pause - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && hold_cycles == 0) @(posedge clk);
    end
  end

  initial begin : result_check
    outcome_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          log_mismatch($sformatf("result with nothing pending: status %0d count %0d type %0d",
                                 status, valid_count, block_type_now));
        end else begin
          want = pending_outcomes.pop_front();
          results_checked++;
          if (status !== want.status)
            log_mismatch($sformatf("status expected %0d got %0d", want.status, status));
          if (valid_count !== want.count)
            log_mismatch($sformatf("valid_count expected %0d got %0d", want.count, valid_count));
          if (block_type_now !== want.kind)
            log_mismatch($sformatf("block_type_now expected %0d got %0d",
                                   want.kind, block_type_now));
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_outcomes.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    action         <= pvt_pkg::ACT_MARK_VALID;
    flash_number   <= '0;
    plane_number   <= '0;
    block_number   <= '0;
    page_number    <= '0;
    new_block_type <= '0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    hold_cycles    = 0;
    empty_code     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_page_marks();
    test_block_type();
    test_out_of_range();
    test_count_saturation();
    test_back_pressure();
    test_random_traffic(300, 3'd0, 1'b1, 1'b1);
    test_random_traffic(300, 3'd7, 1'b0, 1'b0);
    test_random_traffic(300, 3'd3, 1'b1, 1'b0);
    test_random_traffic(300, pvt_pkg::TYPE_W'($urandom_range(0, 7)), 1'b0, 1'b1);
    test_back_pressure();
    test_random_traffic(300, pvt_pkg::TYPE_W'($urandom_range(0, 7)), 1'b1, 1'b1);

    finish_burst();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests (%0d out of range), checked %0d results, %0d mismatches.",
             requests_sent, requests_bad, results_checked, mismatches);
    $display("Covered %0d empty-code writes, long output holds and gap-free bursts.",
             code_writes);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/pvt_pkg.sv
hdl/pvt_ctrl.sv
hdl/pvt_dp.sv
hdl/page_validity_tracker_top.sv
tb/testbench.sv
